// ===== sv/tbws_pkg.sv =====
package tbws_pkg;

  // Window geometry.
  localparam int NUM_BUCKETS = 10;
  localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);
  localparam int IDX_W       = 4;

  // Field widths.
  localparam int WORD_W = 32;
  localparam int LEN_W  = 16;

  localparam logic [LEN_W-1:0] BUCKET_MS_RST = 16'd1000;

  // Divider geometry: three lanes share one step counter.
  localparam int DIVD_W     = WORD_W;
  localparam int DIVS_W     = LEN_W;
  localparam int DIV_STEP_W = $clog2(DIVD_W + 1);
  localparam int DIV_LANES  = 3;
  localparam int LANE_NOW   = 0;
  localparam int LANE_LAST  = 1;
  localparam int LANE_VAL   = 2;

  // Input codes.
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;
  localparam logic RES_PEAK   = 1'b0;
  localparam logic RES_INTV   = 1'b1;

  typedef logic [DIVD_W-1:0] div_word_t;
  typedef logic [DIVS_W-1:0] div_rem_t;

  typedef struct packed {
    logic              cmd;
    logic              resource;
    logic [WORD_W-1:0] now_ms;
    logic [WORD_W-1:0] value;
  } tbws_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  bucket_index;
    logic [WORD_W-1:0] bucket_value;
    logic              last;
  } tbws_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic age_step;
    logic apply;
    logic emit;
  } tbws_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_busy;
    logic shift_zero;
    logic is_read;
    logic out_free;
    logic emit_last;
  } tbws_sts_t;

endpackage

// ===== sv/tbws_div.sv =====
module tbws_div import tbws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start_i,
  input  div_rem_t  divisor_i,
  input  div_word_t dividend_i [DIV_LANES],
  output logic      busy_o,
  output div_word_t quot_o [DIV_LANES],
  output div_rem_t  rem_o [DIV_LANES]
);

  // Restoring division, one quotient bit per lane per cycle. The dividend
  // register fills up with quotient bits from the bottom as it shifts out.
  div_word_t             acc_r [DIV_LANES];
  div_word_t             acc_nxt [DIV_LANES];
  div_rem_t              rem_r [DIV_LANES];
  div_rem_t              rem_nxt [DIV_LANES];
  div_rem_t              dvs_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic                  busy_r;

  always_comb begin
    logic [DIVS_W:0] trial;
    logic [DIVS_W:0] diff;
    trial = '0;
    diff  = '0;
    for (int l = 0; l < DIV_LANES; l++) begin
      trial = {rem_r[l], acc_r[l][DIVD_W-1]};
      diff  = trial - {1'b0, dvs_r};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt[l] = diff[DIVS_W-1:0];
        acc_nxt[l] = {acc_r[l][DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = trial[DIVS_W-1:0];
        acc_nxt[l] = {acc_r[l][DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      step_r <= DIV_STEP_W'(DIVD_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == DIV_STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      dvs_r <= divisor_i;
      for (int l = 0; l < DIV_LANES; l++) begin
        acc_r[l] <= dividend_i[l];
        rem_r[l] <= '0;
      end
    end else if (busy_r) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        acc_r[l] <= acc_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  assign busy_o = busy_r;
  assign quot_o = acc_r;
  assign rem_o  = rem_r;

endmodule

// ===== sv/tbws_ctrl.sv =====
module tbws_ctrl import tbws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tbws_sts_t sts_i,
  output tbws_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_CALC  = 6'b000100,
    ST_AGE   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_nxt  = ST_AGE;
      end
      ST_AGE: begin
        if (sts_i.shift_zero) begin
          state_nxt = sts_i.is_read ? ST_EMIT : ST_APPLY;
        end else begin
          cmd_o.age_step = 1'b1;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready_o = (state_r == ST_IDLE);

endmodule

// ===== sv/tbws_datapath.sv =====
module tbws_datapath import tbws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tbws_cmd_t        cmd_i,
  output tbws_sts_t        sts_o,
  input  logic [LEN_W-1:0] bucket_ms_i,
  input  tbws_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tbws_out_t        out_data_o
);

  // Both windows live in flip-flops. Every access is at a fixed position:
  // ageing shifts by one bucket per cycle and readout rotates the bank.
  logic [WORD_W-1:0] peak_r [NUM_BUCKETS];
  logic [WORD_W-1:0] peak_nxt [NUM_BUCKETS];
  logic [WORD_W-1:0] intv_r [NUM_BUCKETS];
  logic [WORD_W-1:0] intv_nxt [NUM_BUCKETS];
  logic [WORD_W-1:0] last_time_r;
  logic [WORD_W-1:0] last_sample_r;
  logic [WORD_W-1:0] last_sample_nxt;

  logic              cmd_r;
  logic              res_r;
  logic [WORD_W-1:0] val_r;
  logic [LEN_W-1:0]  len_r;
  logic [CNT_W-1:0]  shift_cnt_r;
  logic [CNT_W-1:0]  fill_cnt_r;
  logic [WORD_W-1:0] first_r;
  logic [CNT_W-1:0]  emit_cnt_r;
  logic              out_valid_r;
  tbws_out_t         out_data_r;

  logic [LEN_W-1:0]  len_eff;
  logic              div_busy;
  div_word_t         div_dividend [DIV_LANES];
  div_word_t         div_quot [DIV_LANES];
  div_rem_t          div_rem [DIV_LANES];

  logic [WORD_W-1:0] diff_q;
  logic [WORD_W-1:0] cap_q;
  logic [WORD_W-1:0] more_q;
  logic [WORD_W-1:0] first_q;
  logic              emit_last;
  logic              out_free;

  // A bucket length of zero counts as one millisecond.
  assign len_eff = (bucket_ms_i == '0) ? LEN_W'(1) : bucket_ms_i;

  assign div_dividend[LANE_NOW]  = in_data_i.now_ms;
  assign div_dividend[LANE_LAST] = last_time_r;
  assign div_dividend[LANE_VAL]  = in_data_i.value;

  tbws_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.load),
    .divisor_i  (len_eff),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Bucket boundaries crossed, wrapping, then capped per resource. The peak
  // window never shifts out its newest bucket.
  assign diff_q = div_quot[LANE_NOW] - div_quot[LANE_LAST];
  assign cap_q  = (res_r == RES_PEAK) ? WORD_W'(NUM_BUCKETS - 1) : WORD_W'(NUM_BUCKETS);

  // The newest bucket takes the remainder, or a full bucket when the duration
  // divides evenly; each full bucket left over goes one position older.
  always_comb begin
    if (div_rem[LANE_VAL] != '0) begin
      first_q = WORD_W'(div_rem[LANE_VAL]);
      more_q  = div_quot[LANE_VAL];
    end else if (val_r != '0) begin
      first_q = WORD_W'(len_r);
      more_q  = div_quot[LANE_VAL] - 1'b1;
    end else begin
      first_q = '0;
      more_q  = '0;
    end
  end

  assign emit_last = (emit_cnt_r == CNT_W'(NUM_BUCKETS - 1));
  assign out_free  = !out_valid_r || out_ready_i;

  always_comb begin
    logic [WORD_W:0]   sum_v;
    logic [WORD_W-1:0] add_v;
    sum_v           = '0;
    add_v           = '0;
    peak_nxt        = peak_r;
    intv_nxt        = intv_r;
    last_sample_nxt = last_sample_r;

    if (cmd_i.age_step) begin
      if (res_r == RES_PEAK) begin
        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
          peak_nxt[i] = peak_r[i + 1];
        end
        peak_nxt[NUM_BUCKETS-1] = last_sample_r;
      end else begin
        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
          intv_nxt[i] = intv_r[i + 1];
        end
        intv_nxt[NUM_BUCKETS-1] = '0;
      end
    end

    if (cmd_i.apply) begin
      if (res_r == RES_PEAK) begin
        if (val_r > peak_r[NUM_BUCKETS-1]) begin
          peak_nxt[NUM_BUCKETS-1] = val_r;
        end
        last_sample_nxt = val_r;
      end else begin
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          if (i == NUM_BUCKETS - 1) begin
            add_v = first_r;
          end else if ((NUM_BUCKETS - 1 - i) <= int'(fill_cnt_r)) begin
            add_v = WORD_W'(len_r);
          end else begin
            add_v = '0;
          end
          sum_v       = {1'b0, intv_r[i]} + {1'b0, add_v};
          intv_nxt[i] = sum_v[WORD_W] ? '1 : sum_v[WORD_W-1:0];
        end
      end
    end

    // Readout rotates the bank once per word; a full readout restores it.
    if (cmd_i.emit) begin
      if (res_r == RES_PEAK) begin
        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
          peak_nxt[i] = peak_r[i + 1];
        end
        peak_nxt[NUM_BUCKETS-1] = peak_r[0];
      end else begin
        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
          intv_nxt[i] = intv_r[i + 1];
        end
        intv_nxt[NUM_BUCKETS-1] = intv_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        peak_r[i] <= '0;
        intv_r[i] <= '0;
      end
      last_time_r   <= '0;
      last_sample_r <= '0;
      shift_cnt_r   <= '0;
      emit_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      peak_r        <= peak_nxt;
      intv_r        <= intv_nxt;
      last_sample_r <= last_sample_nxt;
      if (cmd_i.load) begin
        last_time_r <= in_data_i.now_ms;
        emit_cnt_r  <= '0;
      end
      if (cmd_i.calc) begin
        shift_cnt_r <= (diff_q > cap_q) ? CNT_W'(cap_q) : CNT_W'(diff_q);
      end else if (cmd_i.age_step) begin
        shift_cnt_r <= shift_cnt_r - 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_r <= 1'b1;
        emit_cnt_r  <= emit_cnt_r + 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_data_i.cmd;
      res_r <= in_data_i.resource;
      val_r <= in_data_i.value;
      len_r <= len_eff;
    end
    if (cmd_i.calc) begin
      first_r    <= first_q;
      fill_cnt_r <= (more_q > WORD_W'(NUM_BUCKETS - 1)) ? CNT_W'(NUM_BUCKETS - 1)
                                                        : CNT_W'(more_q);
    end
    if (cmd_i.emit) begin
      out_data_r.bucket_index <= IDX_W'(emit_cnt_r);
      out_data_r.bucket_value <= (res_r == RES_PEAK) ? peak_r[0] : intv_r[0];
      out_data_r.last         <= emit_last;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.div_busy   = div_busy;
    sts_o.shift_zero = (shift_cnt_r == '0);
    sts_o.is_read    = (cmd_r == CMD_READ);
    sts_o.out_free   = out_free;
    sts_o.emit_last  = emit_last;
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

// ===== sv/time_bucketed_window_stats_core.sv =====
// A record passes through the divider, the calculation step, the ageing of S buckets and the
// update, and then the block is ready again, where S (0 to NUM_BUCKETS) is the number of buckets
// aged; a read passes through the same steps up to the ageing, then shows one word per cycle while
// the consumer takes them, and is ready again once its last word has been emitted.
// Throughput is set by the bit-serial divider and the one-bucket-per-cycle ageing.
// Reset (synchronous, rst_n low) clears both windows, the last timestamp and the last peak
// sample, empties the output register, and sets bucket_ms to 1000.
module time_bucketed_window_stats_core import tbws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  tbws_in_t    in_data,

  output logic        out_valid,
  input  logic        out_ready,
  output tbws_out_t   out_data,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // The block handles one word at a time. An accepted word starts three
  // divisions in parallel (the new timestamp, the previous timestamp and the
  // sample value, each by the bucket length). The difference of the first two
  // quotients is how many bucket boundaries have passed; the window of the
  // addressed resource then shifts one bucket per cycle that many times, capped per resource.
  //
  // A peak record keeps the larger of the newest bucket and the sample. An
  // interval record spreads the duration backward: the remainder (or a full
  // bucket when the duration divides evenly) lands in the newest bucket and
  // each further full bucket one position older, all in a single cycle with
  // saturating adders. A read streams every bucket, oldest first, through the
  // output register, rotating the window so that it ends as it began.

  // There is one register, so the whole address range maps onto bucket_ms.
  logic [LEN_W-1:0] bucket_ms_r;
  tbws_cmd_t        cmd;
  tbws_sts_t        sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_ms_r <= BUCKET_MS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      bucket_ms_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_prdata = 32'(bucket_ms_r);
  assign cfg_pready = 1'b1;

  tbws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tbws_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .bucket_ms_i (bucket_ms_r),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

endmodule
